>>> hw/rtl/assert_macros.svh
// Assertion macros for the port checker module of this block.
// Each macro expands to one labelled concurrent assertion that reports through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define CBOT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define CBOT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/cbot_pkg.sv
// ----------------------------------------------------------------------------
// cbot_pkg
// Types and constants shared by the coverage bitmap occlusion test modules.
// ----------------------------------------------------------------------------
package cbot_pkg;

    localparam int SCREEN_WIDTH_DEF  = 64;
    localparam int SCREEN_HEIGHT_DEF = 64;

    typedef logic signed [11:0] coord_t;

    typedef struct packed {
        coord_t lo;
        coord_t hi;
    } coord_pair_t;

    typedef struct packed {
        logic        kind;
        coord_t      corner0_x;
        coord_t      corner0_y;
        coord_t      corner1_x;
        coord_t      corner1_y;
        coord_t      corner2_x;
        coord_t      corner2_y;
        coord_t      corner3_x;
        coord_t      corner3_y;
        logic        group_end;
        logic [15:0] chunk_tag;
    } in_item_t;

    typedef struct packed {
        logic        visible;
        logic [15:0] result_tag;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MASK,
        ST_DRAW,
        ST_TEST,
        ST_TEST_DONE,
        ST_PEND,
        ST_PEND_DONE,
        ST_MERGE,
        ST_FINISH
    } ctrl_state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_DRAW,
        OP_TEST,
        OP_PEND,
        OP_MERGE
    } row_op_t;

    typedef enum logic {
        ROW_SEL_RECT,
        ROW_SEL_ZERO
    } row_sel_t;

    typedef struct packed {
        logic     load_item;
        logic     load_mask;
        logic     row_load;
        row_sel_t row_sel;
        row_op_t  op;
        logic     load_result;
    } dp_cmd_t;

    typedef struct packed {
        logic is_query;
        logic group_end;
        logic empty;
        logic last_row;
        logic visible;
        logic out_free;
    } dp_status_t;

endpackage

>>> hw/rtl/cbot_ctrl.sv
// ----------------------------------------------------------------------------
// cbot_ctrl
// Sequencer that walks each item through its row passes over the bitmaps.
// ----------------------------------------------------------------------------
module cbot_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  cbot_pkg::dp_status_t status,
    output cbot_pkg::dp_cmd_t    cmd
);
    import cbot_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.last_row)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_MASK;
                end
            end
            ST_MASK:
            begin
                if (status.empty)
                begin
                    state_next = (status.is_query && status.group_end) ? ST_MERGE : ST_FINISH;
                end
                else
                begin
                    state_next = status.is_query ? ST_TEST : ST_DRAW;
                end
            end
            ST_DRAW:
            begin
                if (status.last_row)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_TEST:
            begin
                if (status.last_row)
                begin
                    state_next = ST_TEST_DONE;
                end
            end
            ST_TEST_DONE:
            begin
                if (status.visible)
                begin
                    state_next = ST_PEND;
                end
                else
                begin
                    state_next = status.group_end ? ST_MERGE : ST_FINISH;
                end
            end
            ST_PEND:
            begin
                if (status.last_row)
                begin
                    state_next = ST_PEND_DONE;
                end
            end
            ST_PEND_DONE:
            begin
                state_next = status.group_end ? ST_MERGE : ST_FINISH;
            end
            ST_MERGE:
            begin
                if (status.last_row)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!status.is_query || status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        cmd.op     = OP_NONE;
        item_stall = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.op = OP_CLEAR;
            end
            ST_IDLE:
            begin
                item_stall    = 1'b0;
                cmd.load_item = item_valid;
            end
            ST_MASK:
            begin
                cmd.load_mask = 1'b1;
                cmd.row_load  = 1'b1;
                cmd.row_sel   = status.empty ? ROW_SEL_ZERO : ROW_SEL_RECT;
            end
            ST_DRAW:
            begin
                cmd.op = OP_DRAW;
            end
            ST_TEST:
            begin
                cmd.op = OP_TEST;
            end
            ST_TEST_DONE:
            begin
                cmd.row_load = 1'b1;
                cmd.row_sel  = status.visible ? ROW_SEL_RECT : ROW_SEL_ZERO;
            end
            ST_PEND:
            begin
                cmd.op = OP_PEND;
            end
            ST_PEND_DONE:
            begin
                cmd.row_load = 1'b1;
                cmd.row_sel  = ROW_SEL_ZERO;
            end
            ST_MERGE:
            begin
                cmd.op = OP_MERGE;
            end
            ST_FINISH:
            begin
                cmd.load_result = status.is_query && status.out_free;
            end
            default:
            begin
                cmd.op = OP_NONE;
            end
        endcase
    end

endmodule

>>> hw/rtl/cbot_datapath.sv
// ----------------------------------------------------------------------------
// cbot_datapath
// Rectangle setup, span mask, row counter, both bitmaps and the result register.
// ----------------------------------------------------------------------------
module cbot_datapath #(
    parameter int SCREEN_WIDTH  = cbot_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = cbot_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cbot_pkg::in_item_t   item_data,
    input  cbot_pkg::dp_cmd_t    cmd,
    output cbot_pkg::dp_status_t status,
    input  logic                 result_stall,
    output logic                 result_valid,
    output cbot_pkg::out_item_t  result_data
);
    import cbot_pkg::*;

    localparam int                  ROW_W      = $clog2(SCREEN_HEIGHT);
    localparam logic [ROW_W-1:0]    LAST_ROW   = ROW_W'(SCREEN_HEIGHT - 1);
    localparam coord_t              WIDTH_LIM  = 12'(SCREEN_WIDTH);
    localparam coord_t              HEIGHT_LIM = 12'(SCREEN_HEIGHT);

    // Second and third smallest of four values, by compare-exchange of each pair, then of the middle two.
    function automatic coord_pair_t mid2(coord_t a, coord_t b, coord_t c, coord_t d);
        coord_t      l1;
        coord_t      h1;
        coord_t      l2;
        coord_t      h2;
        coord_t      m1;
        coord_t      m2;
        coord_pair_t r;
        l1   = (a < b) ? a : b;
        h1   = (a < b) ? b : a;
        l2   = (c < d) ? c : d;
        h2   = (c < d) ? d : c;
        m1   = (l1 > l2) ? l1 : l2;
        m2   = (h1 < h2) ? h1 : h2;
        r.lo = (m1 < m2) ? m1 : m2;
        r.hi = (m1 < m2) ? m2 : m1;
        return r;
    endfunction

    // Item registers.
    logic        kind_reg;
    logic        gend_reg;
    logic [15:0] tag_reg;
    coord_t      x0_reg;
    coord_t      x1_reg;
    coord_t      y0_reg;
    coord_t      y1_reg;

    coord_pair_t xs;
    coord_pair_t ys;
    coord_t      xs_lo;
    coord_t      xs_hi;
    coord_t      ys_lo;
    coord_t      ys_hi;
    coord_t      x0_next;
    coord_t      x1_next;
    coord_t      y0_next;
    coord_t      y1_next;

    always_comb
    begin
        xs      = mid2(item_data.corner0_x, item_data.corner1_x,
                       item_data.corner2_x, item_data.corner3_x);
        ys      = mid2(item_data.corner0_y, item_data.corner1_y,
                       item_data.corner2_y, item_data.corner3_y);
        xs_lo   = xs.lo;
        xs_hi   = xs.hi;
        ys_lo   = ys.lo;
        ys_hi   = ys.hi;
        x0_next = (xs_lo < 12'sd0) ? 12'sd0 : xs_lo;
        y0_next = (ys_lo < 12'sd0) ? 12'sd0 : ys_lo;
        x1_next = (xs_hi > WIDTH_LIM) ? WIDTH_LIM : xs_hi;
        y1_next = (ys_hi > HEIGHT_LIM) ? HEIGHT_LIM : ys_hi;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            kind_reg <= item_data.kind;
            gend_reg <= item_data.group_end;
            tag_reg  <= item_data.chunk_tag;
            x0_reg   <= x0_next;
            x1_reg   <= x1_next;
            y0_reg   <= y0_next;
            y1_reg   <= y1_next;
        end
    end

    logic   empty;
    coord_t y1_less;

    assign empty   = (x0_reg >= x1_reg) || (y0_reg >= y1_reg);
    assign y1_less = y1_reg - 12'sd1;

    // Span mask: one bit per column, set inside [x0, x1).
    logic [SCREEN_WIDTH-1:0] mask_reg;
    logic [SCREEN_WIDTH-1:0] mask_next;

    always_comb
    begin
        for (int i = 0; i < SCREEN_WIDTH; i++)
        begin
            mask_next[i] = (12'(i) >= x0_reg) && (12'(i) < x1_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_mask)
        begin
            mask_reg <= mask_next;
        end
    end

    // Row counter and the last row of the current pass.
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] end_row_reg;
    logic [ROW_W-1:0] wr_row_reg;
    row_op_t          op_q_reg;
    logic             rd_en;

    assign rd_en = (cmd.op != OP_NONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg     <= '0;
            end_row_reg <= LAST_ROW;
            op_q_reg    <= OP_NONE;
        end
        else
        begin
            op_q_reg <= cmd.op;
            if (cmd.row_load)
            begin
                if (cmd.row_sel == ROW_SEL_RECT)
                begin
                    row_reg     <= y0_reg[ROW_W-1:0];
                    end_row_reg <= y1_less[ROW_W-1:0];
                end
                else
                begin
                    row_reg     <= '0;
                    end_row_reg <= LAST_ROW;
                end
            end
            else if (rd_en)
            begin
                row_reg <= row_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wr_row_reg <= row_reg;
    end

    // Bitmaps: read one row per cycle, write the modified row in the next cycle.
    logic [SCREEN_WIDTH-1:0] cov_mem  [SCREEN_HEIGHT];
    logic [SCREEN_WIDTH-1:0] pend_mem [SCREEN_HEIGHT];
    logic [SCREEN_WIDTH-1:0] cov_q_reg;
    logic [SCREEN_WIDTH-1:0] pend_q_reg;
    logic [SCREEN_WIDTH-1:0] cov_wdata;
    logic [SCREEN_WIDTH-1:0] pend_wdata;
    logic                    cov_we;
    logic                    pend_we;

    always_comb
    begin
        cov_we     = 1'b0;
        pend_we    = 1'b0;
        cov_wdata  = cov_q_reg;
        pend_wdata = pend_q_reg;
        unique case (op_q_reg)
            OP_CLEAR:
            begin
                cov_we     = 1'b1;
                pend_we    = 1'b1;
                cov_wdata  = '0;
                pend_wdata = '0;
            end
            OP_DRAW:
            begin
                cov_we    = 1'b1;
                cov_wdata = cov_q_reg | mask_reg;
            end
            OP_PEND:
            begin
                pend_we    = 1'b1;
                pend_wdata = pend_q_reg | mask_reg;
            end
            OP_MERGE:
            begin
                cov_we     = 1'b1;
                pend_we    = 1'b1;
                cov_wdata  = cov_q_reg | pend_q_reg;
                pend_wdata = '0;
            end
            default:
            begin
                cov_we  = 1'b0;
                pend_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cov_we)
        begin
            cov_mem[wr_row_reg] <= cov_wdata;
        end
        if (rd_en)
        begin
            cov_q_reg <= cov_mem[row_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_we)
        begin
            pend_mem[wr_row_reg] <= pend_wdata;
        end
        if (rd_en)
        begin
            pend_q_reg <= pend_mem[row_reg];
        end
    end

    // Visibility accumulates over the test pass.
    logic vis_reg;
    logic vis_next;
    logic hit;

    assign hit      = (op_q_reg == OP_TEST) && (|(mask_reg & ~cov_q_reg));
    assign vis_next = vis_reg | hit;

    always_ff @(posedge clk)
    begin
        vis_reg <= cmd.load_item ? 1'b0 : vis_next;
    end

    // Result register.
    logic      result_valid_reg;
    out_item_t result_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.load_result)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            result_data_reg.visible    <= vis_reg;
            result_data_reg.result_tag <= tag_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;

    always_comb
    begin
        status.is_query  = kind_reg;
        status.group_end = gend_reg;
        status.empty     = empty;
        status.last_row  = (row_reg == end_row_reg);
        status.visible   = vis_next;
        status.out_free  = !result_valid_reg || !result_stall;
    end

endmodule

>>> hw/rtl/coverage_bitmap_occlusion_test_unit.sv
// ----------------------------------------------------------------------------
// coverage_bitmap_occlusion_test_unit: coverage bitmap occlusion test
// After reset a clearing pass over every row stalls the input.
// ----------------------------------------------------------------------------
//
// Every item carries a quad of four corners. The inner rectangle runs from
// the second to the third smallest corner coordinate on each axis, the
// upper bound exclusive, and is clipped to the screen when the item is
// accepted. A span mask of the clipped columns is then built and registered.
//
// The bitmaps hold one screen row per memory word. Each pass walks the rows
// of the rectangle one per cycle: the row is read, and the modified row is
// written back in the following cycle, so the bitmap port sets the rate.
// A draw ORs the mask into the coverage bitmap. A query first tests every
// row for an uncovered pixel, and then, if it found one, ORs the mask into
// the pending bitmap in a second pass. A query flagged as group end is
// followed by a sweep over the whole screen that merges pending coverage
// into the coverage bitmap and clears the pending bitmap.
//
// An empty rectangle skips its row passes. A draw gives no result item; a
// query gives exactly one, held in an output register, so the next item is
// accepted while the result still waits to be taken.
//
// Reset clears both bitmaps by a clearing pass through every row.
module coverage_bitmap_occlusion_test_unit #(
    parameter int SCREEN_WIDTH  = cbot_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = cbot_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  cbot_pkg::in_item_t  item_data,
    output logic                result_valid,
    input  logic                result_stall,
    output cbot_pkg::out_item_t result_data
);
    import cbot_pkg::*;

    // Commands from the sequencer, status back from the datapath.
    dp_cmd_t    cmd;
    dp_status_t status;

    cbot_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    cbot_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_data    (item_data),
        .cmd          (cmd),
        .status       (status),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result_data  (result_data)
    );

endmodule

>>> hw/rtl/cbot_checker.sv
// ----------------------------------------------------------------------------
// cbot_port_checker
// Port-level checks on the occlusion test unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cbot_port_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                item_valid,
    input logic                item_stall,
    input logic                result_valid,
    input logic                result_stall,
    input cbot_pkg::out_item_t result_data
);
    import cbot_pkg::*;

    logic item_taken;

    assign item_taken = item_valid && !item_stall;

    // The clearing pass after reset keeps the input stalled.
    `CBOT_ASSERT_ALWAYS(a_stall_after_reset, clk, !rst_n |=> item_stall, "input open during clear")

    // Items are worked on one at a time, so an accepted item closes the input.
    `CBOT_ASSERT(a_one_item_at_a_time, clk, rst_n, item_taken |=> item_stall, "back-to-back accept")

    // No result can be produced in the cycle right after an item is accepted.
    `CBOT_ASSERT(a_no_early_result, clk, rst_n, item_taken |=> !$rose(result_valid), "result too early")

    // A stalled result stays offered and unchanged.
    `CBOT_ASSERT(a_result_held, clk, rst_n, result_valid && result_stall |=> result_valid, "result dropped")
    `CBOT_ASSERT(a_result_stable, clk, rst_n, result_valid && result_stall |=> $stable(result_data), "result changed")

endmodule

bind coverage_bitmap_occlusion_test_unit cbot_port_checker u_cbot_checker (.*);

>>> tb/cbot_tb_pkg.sv
// ----------------------------------------------------------------------------
// cbot_tb_pkg
// Item kind codes shared by the occlusion test bench and its checker.
// ----------------------------------------------------------------------------
package cbot_tb_pkg;

    // Meaning of the kind field of an input item.
    typedef enum logic {
        KIND_DRAW  = 1'b0,
        KIND_QUERY = 1'b1
    } item_kind_t;

endpackage

>>> tb/cbot_checker.sv
// ----------------------------------------------------------------------------
// cbot_checker
// Watches both channels of the occlusion test unit, keeps its own coverage
// and pending bitmaps, predicts the answer to every accepted query and
// compares each accepted result item against the oldest prediction.
// ----------------------------------------------------------------------------
module cbot_checker #(
    parameter int SCREEN_W = cbot_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_H = cbot_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                item_stall,
    input  cbot_pkg::in_item_t  item_data,
    input  logic                result_valid,
    input  logic                result_stall,
    input  cbot_pkg::out_item_t result_data,
    output int                  fail_count,
    output int                  awaiting
);

    import cbot_pkg::*;
    import cbot_tb_pkg::*;

    logic [SCREEN_W-1:0] cover_rows   [SCREEN_H];
    logic [SCREEN_W-1:0] pending_rows [SCREEN_H];
    out_item_t           answer_q     [$];

    // Second and third smallest of the four corner coordinates on one axis.
    function automatic coord_pair_t inner_span(coord_t a, coord_t b, coord_t c, coord_t d);
        coord_t      v [4];
        coord_t      t;
        coord_pair_t span;
        int          i;
        int          j;
        v[0] = a;
        v[1] = b;
        v[2] = c;
        v[3] = d;
        for (i = 1; i < 4; i++)
        begin
            for (j = i; j > 0; j--)
            begin
                if (v[j-1] > v[j])
                begin
                    t      = v[j];
                    v[j]   = v[j-1];
                    v[j-1] = t;
                end
            end
        end
        span.lo = v[1];
        span.hi = v[2];
        return span;
    endfunction

    // Applies one accepted item to the bitmaps and queues the answer of a query.
    task automatic apply_quad(in_item_t it);
        coord_pair_t         xs;
        coord_pair_t         ys;
        int                  x0;
        int                  x1;
        int                  y0;
        int                  y1;
        int                  x;
        int                  y;
        logic [SCREEN_W-1:0] mask;
        logic                seen;
        out_item_t           answer;
        xs = inner_span(it.corner0_x, it.corner1_x, it.corner2_x, it.corner3_x);
        ys = inner_span(it.corner0_y, it.corner1_y, it.corner2_y, it.corner3_y);
        x0 = $signed(xs.lo);
        x1 = $signed(xs.hi);
        y0 = $signed(ys.lo);
        y1 = $signed(ys.hi);
        if (x0 < 0)
            x0 = 0;
        if (y0 < 0)
            y0 = 0;
        if (x1 > SCREEN_W)
            x1 = SCREEN_W;
        if (y1 > SCREEN_H)
            y1 = SCREEN_H;
        mask = '0;
        for (x = 0; x < SCREEN_W; x++)
        begin
            if (x >= x0 && x < x1)
                mask[x] = 1'b1;
        end
        if (it.kind == KIND_DRAW)
        begin
            for (y = 0; y < SCREEN_H; y++)
            begin
                if (y >= y0 && y < y1)
                    cover_rows[y] = cover_rows[y] | mask;
            end
        end
        else
        begin
            seen = 1'b0;
            for (y = 0; y < SCREEN_H; y++)
            begin
                if (y >= y0 && y < y1 && (mask & ~cover_rows[y]) != '0)
                    seen = 1'b1;
            end
            if (seen)
            begin
                for (y = 0; y < SCREEN_H; y++)
                begin
                    if (y >= y0 && y < y1)
                        pending_rows[y] = pending_rows[y] | mask;
                end
            end
            if (it.group_end)
            begin
                for (y = 0; y < SCREEN_H; y++)
                begin
                    cover_rows[y]   = cover_rows[y] | pending_rows[y];
                    pending_rows[y] = '0;
                end
            end
            answer.visible    = seen;
            answer.result_tag = it.chunk_tag;
            answer_q          = {answer_q, answer};
        end
    endtask

    // The result is checked before the item of the same edge is applied, so a
    // result can never be matched against a query accepted at that very edge.
    always @(posedge clk or negedge rst_n)
    begin : watch
        out_item_t want;
        int        bad;
        int        r;
        if (!rst_n)
        begin
            for (r = 0; r < SCREEN_H; r++)
            begin
                cover_rows[r]   = '0;
                pending_rows[r] = '0;
            end
            answer_q.delete();
            fail_count <= 0;
            awaiting   <= 0;
        end
        else
        begin
            bad = 0;
            if (result_valid && !result_stall)
            begin
                if (answer_q.size() == 0)
                begin
                    $error("result item with tag %h arrived with no query outstanding",
                           result_data.result_tag);
                    bad++;
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (result_data.visible !== want.visible)
                    begin
                        $error("visible: expected %0d, actual %0d",
                               want.visible, result_data.visible);
                        bad++;
                    end
                    if (result_data.result_tag !== want.result_tag)
                    begin
                        $error("result_tag: expected %h, actual %h",
                               want.result_tag, result_data.result_tag);
                        bad++;
                    end
                end
            end
            if (item_valid && !item_stall)
                apply_quad(item_data);
            fail_count <= fail_count + bad;
            awaiting   <= answer_q.size();
        end
    end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the coverage bitmap occlusion test unit: a short
// directed sequence followed by depth groups of random quads under several
// idling patterns, with a checker instance doing all prediction.
// ----------------------------------------------------------------------------
module tb_top;

    import cbot_pkg::*;
    import cbot_tb_pkg::*;

    // A full-screen query with a group end is the longest item, and the
    // watchdog is set well clear of it and of the long receiver hold-off.
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int STALL_LIMIT      = 5000;
    localparam int TAIL_CYCLES      = 200;
    localparam int HALF_PHASE_ITEMS = 104;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      item_valid;
    logic      item_stall;
    in_item_t  item_data;
    logic      result_valid;
    logic      result_stall;
    out_item_t result_data;

    int fail_count;
    int awaiting;

    // Idling percentages of the current phase, changed only at a rising edge.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // Requests for a long receiver hold-off and how many have been served.
    int hold_asked = 0;
    int hold_done  = 0;

    int quiet_cycles = 0;
    int phase;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    coverage_bitmap_occlusion_test_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item_data    (item_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    cbot_checker occl_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item_data    (item_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .fail_count   (fail_count),
        .awaiting     (awaiting)
    );

    // Builds an item from four explicit corners per axis.
    function automatic in_item_t quad_item(item_kind_t k,
                                           int ax, int bx, int cx, int dx,
                                           int ay, int by, int cy, int dy,
                                           logic gend, logic [15:0] tag);
        in_item_t it;
        it.kind      = k;
        it.corner0_x = coord_t'(ax);
        it.corner1_x = coord_t'(bx);
        it.corner2_x = coord_t'(cx);
        it.corner3_x = coord_t'(dx);
        it.corner0_y = coord_t'(ay);
        it.corner1_y = coord_t'(by);
        it.corner2_y = coord_t'(cy);
        it.corner3_y = coord_t'(dy);
        it.group_end = gend;
        it.chunk_tag = tag;
        return it;
    endfunction

    // Builds a quad whose inner rectangle is exactly [x0, x1) by [y0, y1).
    // The corners are deliberately given out of order, with the outer two
    // corners on each axis just beyond the rectangle.
    function automatic in_item_t rect_item(item_kind_t k, int x0, int x1, int y0, int y1,
                                           logic gend, logic [15:0] tag);
        return quad_item(k, x1, x0 - 1, x1 + 2, x0, y0 - 3, y1 + 1, y0, y1, gend, tag);
    endfunction

    // One corner coordinate: mostly near a centre on or just off the screen,
    // now and then anywhere in the 12-bit range or at either extreme, so
    // that every bit of every corner field is exercised.
    function automatic coord_t rand_corner(int centre, int spread);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return coord_t'($urandom_range(0, 4095));
        if (pick < 14)
            return pick[0] ? coord_t'(2047) : coord_t'(-2048);
        return coord_t'(centre + int'($urandom_range(0, spread)) - spread / 2);
    endfunction

    // A random quad. Most rectangles are only a few pixels on a side, which
    // keeps the row passes short and stops the coverage bitmap filling up
    // too early in the run; roughly one axis in ten is stretched wide.
    function automatic in_item_t random_quad(item_kind_t k, logic gend, logic [15:0] tag);
        in_item_t it;
        int       cx;
        int       cy;
        int       sx;
        int       sy;
        cx = int'($urandom_range(0, 71)) - 4;
        cy = int'($urandom_range(0, 71)) - 4;
        sx = ($urandom_range(0, 9) == 0) ? 90 : int'($urandom_range(0, 8));
        sy = ($urandom_range(0, 9) == 0) ? 90 : int'($urandom_range(0, 8));
        it.kind      = k;
        it.corner0_x = rand_corner(cx, sx);
        it.corner1_x = rand_corner(cx, sx);
        it.corner2_x = rand_corner(cx, sx);
        it.corner3_x = rand_corner(cx, sx);
        it.corner0_y = rand_corner(cy, sy);
        it.corner1_y = rand_corner(cy, sy);
        it.corner2_y = rand_corner(cy, sy);
        it.corner3_y = rand_corner(cy, sy);
        it.group_end = gend;
        it.chunk_tag = tag;
        return it;
    endfunction

    // Offers one item. Idle cycles are inserted first, each with valid low,
    // and the item is then presented at a falling edge and held until a
    // rising edge finds the input not stalled. On return the item has just
    // been accepted and valid is still high, so the caller either offers the
    // next item or lowers valid at the following falling edge.
    task automatic send_item(in_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
        end
        @(negedge clk);
        item_valid <= 1'b1;
        item_data  <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    // Stops offering items and waits until every predicted result has been
    // taken. The count from the checker is read at falling edges, where it
    // is stable.
    task automatic wait_for_results();
        @(negedge clk);
        item_valid <= 1'b0;
        while (awaiting != 0)
            @(negedge clk);
    endtask

    // Mostly well-formed depth groups: a few occluders, then a run of
    // queries of which only the last carries the group end. The rest are
    // single items with every field random, group end on draws included.
    task automatic random_batch(int n);
        int count;
        int draws;
        int queries;
        int k;
        count = 0;
        while (count < n)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                draws   = $urandom_range(0, 2);
                queries = $urandom_range(1, 5);
                for (k = 0; k < draws; k++)
                    send_item(random_quad(KIND_DRAW, 1'($urandom_range(0, 1)),
                                          16'($urandom_range(0, 65535))));
                for (k = 0; k < queries; k++)
                    send_item(random_quad(KIND_QUERY, k == queries - 1,
                                          16'($urandom_range(0, 65535))));
                count += draws + queries;
            end
            else
            begin
                send_item(random_quad(item_kind_t'($urandom_range(0, 1)),
                                      1'($urandom_range(0, 1)),
                                      16'($urandom_range(0, 65535))));
                count++;
            end
        end
    endtask

    // Receiver. Each cycle it stalls at the phase's rate, except when a
    // long hold-off has been asked for: then it stalls for the whole
    // stretch, counted here, whatever the sender is doing.
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_asked != hold_done)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
                hold_done++;
            end
            else
                result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Watchdog: ends the run if neither channel moves an item for too long.
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Stimulus and verdict.
    initial
    begin
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item_data  = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, run without idling on an empty screen. The
        // expected answers are noted beside each item.
        // Full x extremes on a single row: visible, row 0 goes to pending.
        send_item(quad_item(KIND_QUERY, -2048, 2047, -2048, 2047, 0, 1, 1, 0, 1'b0, 16'hFFFF));
        // Zero-width rectangle: not visible.
        send_item(rect_item(KIND_QUERY, 10, 10, 5, 9, 1'b0, 16'h0000));
        // Wholly off the left and wholly off the bottom: not visible.
        send_item(rect_item(KIND_QUERY, -20, -5, 3, 9, 1'b0, 16'h8000));
        send_item(rect_item(KIND_QUERY, 3, 9, 64, 70, 1'b0, 16'h7FFF));
        // An occluder carrying a group end and a tag, both of which are
        // ignored: no result and no merge.
        send_item(rect_item(KIND_DRAW, 0, 8, 8, 16, 1'b1, 16'hABCD));
        // Fully behind the occluder: not visible.
        send_item(rect_item(KIND_QUERY, 0, 8, 8, 16, 1'b0, 16'h0001));
        // Half uncovered: visible, twice, as pending is not yet merged.
        send_item(rect_item(KIND_QUERY, 4, 12, 8, 16, 1'b0, 16'h0002));
        send_item(rect_item(KIND_QUERY, 4, 12, 8, 16, 1'b0, 16'h0003));
        // Group end on a query that is not visible: the merge still happens.
        send_item(rect_item(KIND_QUERY, 0, 4, 8, 12, 1'b1, 16'h0004));
        // Now covered by the merged pending area, row 0 included.
        send_item(rect_item(KIND_QUERY, 4, 12, 8, 16, 1'b0, 16'h0005));
        send_item(rect_item(KIND_QUERY, 0, 64, 0, 1, 1'b0, 16'h0006));
        // Crossing the right and top edges: rows 1 and 2 are still open.
        send_item(rect_item(KIND_QUERY, 60, 70, -5, 3, 1'b0, 16'h0007));
        // Occluders that collapse to nothing at either extreme.
        send_item(quad_item(KIND_DRAW, 2047, 2047, 2047, 2047, 2047, 2047, 2047, 2047,
                            1'b0, 16'hFFFF));
        send_item(quad_item(KIND_DRAW, -2048, -2048, -2048, -2048, -2048, -2048, -2048,
                            -2048, 1'b1, 16'h0000));
        send_item(quad_item(KIND_DRAW, -2048, -2048, 2047, 2047, 5, 5, 5, 5,
                            1'b0, 16'h1234));
        // Distinct corners in no particular order, closing a group.
        send_item(quad_item(KIND_QUERY, 30, 12, 25, 17, 40, 33, 45, 31, 1'b1, 16'h0008));
        send_item(rect_item(KIND_DRAW, 40, 48, 40, 48, 1'b0, 16'h5555));
        send_item(rect_item(KIND_QUERY, 40, 48, 40, 48, 1'b0, 16'h0009));
        send_item(rect_item(KIND_QUERY, 47, 49, 47, 49, 1'b1, 16'h000A));
        // The last pixel of the screen, then a rectangle clipped to nothing.
        send_item(rect_item(KIND_QUERY, 63, 64, 63, 64, 1'b0, 16'h000B));
        send_item(rect_item(KIND_QUERY, 64, 65, 0, 4, 1'b0, 16'h000C));
        // Group end on a rectangle that is empty after clipping.
        send_item(rect_item(KIND_QUERY, 70, 80, 10, 20, 1'b1, 16'h000D));
        wait_for_results();

        // Random part in four idling phases: none, a mostly idle sender, a
        // mostly stalling receiver, and light idling on both sides.
        for (phase = 0; phase < 4; phase++)
        begin
            @(posedge clk);
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 85;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 85;
                end
                default:
                begin
                    send_idle_pct  = 8;
                    recv_stall_pct = 8;
                end
            endcase
            random_batch(HALF_PHASE_ITEMS);
            // With no idling on the sending side, a long hold-off at the
            // receiver fills the output register and backs up the input.
            if (phase == 0)
                hold_asked++;
            // Part-way through the idle-sender phase, let the block drain
            // completely before carrying on.
            if (phase == 1)
                wait_for_results();
            random_batch(HALF_PHASE_ITEMS);
            wait_for_results();
        end

        // Everything predicted has arrived; allow the longest latency for
        // any stray result item before giving the verdict.
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/cbot_pkg.sv
hw/rtl/cbot_ctrl.sv
hw/rtl/cbot_datapath.sv
hw/rtl/coverage_bitmap_occlusion_test_unit.sv
hw/rtl/cbot_checker.sv
tb/cbot_tb_pkg.sv
tb/cbot_checker.sv
tb/tb_top.sv
